>>> hdl/mhpq_pkg.sv
// Shared types, constants and helpers for the max-heap priority queue.
// No dependencies; every other file but mhpq_ram imports this package.
`timescale 1ns / 1ps

package mhpq_pkg;

	// Heap size and derived widths.
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 31;

	// Request operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Response status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               op;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] max_value;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	// Heap store access from the sequencer to the memory.
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [VALUE_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr_a;
		logic [ADDR_W-1:0]  raddr_b;
	} mem_cmd_t;

	// Heap positions are one-based; memory addresses are zero-based.
	function automatic logic [ADDR_W-1:0] pos_addr(input logic [COUNT_W:0] pos);
		logic [COUNT_W:0] dec;
		dec = pos - 1'b1;
		return dec[ADDR_W-1:0];
	endfunction

endpackage

>>> hdl/max_heap_priority_queue.sv
// Channel  Signals                          Direction
// request  req_valid, req_ready, req_data   in  (op, value)
// response rsp_valid, rsp_ready, rsp_data   out (status, max_value, count)
//
// A response is presented once the sequencer has walked the heap: one read-compare-write
// step on the heap store per heap level walked (up to log2(1024) = 10), plus setup and
// hand-off states. The sequencer takes a new request only once the last one has been
// handed to the output register.
// Reset clears the entry count and control state; the store itself is not cleared.
// A finished response waits in an output register, so the next request is taken
// while the response is stalled; the sequencer stalls only if a second one is ready.
// Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
`timescale 1ns / 1ps

module max_heap_priority_queue
	import mhpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	mem_cmd_t           mem;
	logic [VALUE_W-1:0] rdata_a, rdata_b;
	logic               eng_valid, eng_ready;
	rsp_t               eng_rsp;
	logic               out_valid_q;
	rsp_t               out_q;

	mhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VALUE_W)
	) u_ram (
		.clk    (clk),
		.we     (mem.we),
		.waddr  (mem.waddr),
		.wdata  (mem.wdata),
		.raddr_a(mem.raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(mem.raddr_b),
		.rdata_b(rdata_b)
	);

	mhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req_data),
		.rsp_valid(eng_valid),
		.rsp_ready(eng_ready),
		.rsp      (eng_rsp),
		.mem      (mem),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b)
	);

	// Output register between the sequencer and the response channel.
	assign eng_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_ready) begin
			out_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ready && eng_valid) begin
			out_q <= eng_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

>>> hdl/mhpq_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module mhpq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 31,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two read ports, both registered.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hdl/mhpq_ctrl.sv
// Heap sequencer: runs push sift-up and pop sift-down over the heap store.
// Depends on mhpq_pkg; drives the store built from mhpq_ram.
`timescale 1ns / 1ps

module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	output mem_cmd_t           mem,
	input  logic [VALUE_W-1:0] rdata_a,
	input  logic [VALUE_W-1:0] rdata_b
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_UP    = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_DOWN  = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);
	localparam logic [COUNT_W-1:0] ROOT    = COUNT_W'(1);

	logic [2:0]         state_q, state_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic [COUNT_W-1:0] pos_q, pos_d;
	logic [VALUE_W-1:0] val_q, val_d;
	logic               op_q, op_d;
	logic [1:0]         status_q, status_d;
	logic [VALUE_W-1:0] maxv_q, maxv_d;

	logic [COUNT_W-1:0] cnt_inc, cnt_dec, par_pos;
	logic [COUNT_W:0]   l_pos, r_pos, cnt_ext, child;
	logic               l_ok, r_ok, pick_l, pick_r;
	logic [VALUE_W-1:0] cand_v, child_v;

	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_dec = cnt_q - 1'b1;
	assign par_pos = pos_q >> 1;
	assign cnt_ext = {1'b0, cnt_q};
	assign l_pos   = {pos_q, 1'b0};
	assign r_pos   = {pos_q, 1'b1};

	// Child selection for sift-down; the left child wins a tie.
	always_comb begin
		l_ok   = (l_pos <= cnt_ext);
		r_ok   = (r_pos <= cnt_ext);
		pick_l = l_ok && (rdata_a > val_q);
		cand_v = pick_l ? rdata_a : val_q;
		pick_r = r_ok && (rdata_b > cand_v);
		child   = pick_r ? r_pos : l_pos;
		child_v = pick_r ? rdata_b : rdata_a;
	end

	// Next-state and store access logic.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		val_d       = val_q;
		op_d        = op_q;
		status_d    = status_q;
		maxv_d      = maxv_q;
		mem.we      = 1'b0;
		mem.waddr   = pos_addr({1'b0, pos_q});
		mem.wdata   = val_q;
		mem.raddr_a = '0;
		mem.raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_d    = req.op;
					val_d   = req.value;
					state_d = S_START;
				end
			end
			S_START: begin
				status_d = ST_OK;
				maxv_d   = '0;
				if (op_q == OP_PUSH) begin
					if (cnt_q == CAP_CNT) begin
						status_d = ST_FULL;
						state_d  = S_FIN;
					end else begin
						cnt_d = cnt_inc;
						pos_d = cnt_inc;
						if (cnt_q == '0) begin
							mem.we    = 1'b1;
							mem.waddr = '0;
							state_d   = S_FIN;
						end else begin
							mem.raddr_a = pos_addr({1'b0, cnt_inc >> 1});
							state_d     = S_UP;
						end
					end
				end else begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
						state_d  = S_FIN;
					end else begin
						mem.raddr_a = '0;
						mem.raddr_b = pos_addr(cnt_ext);
						state_d     = S_POP;
					end
				end
			end
			S_UP: begin
				mem.we = 1'b1;
				if (val_q > rdata_a) begin
					// Parent moves down into the hole.
					mem.wdata = rdata_a;
					pos_d     = par_pos;
					if (par_pos == ROOT) begin
						state_d = S_PUT;
					end else begin
						mem.raddr_a = pos_addr({1'b0, par_pos >> 1});
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_POP: begin
				maxv_d = rdata_a;
				cnt_d  = cnt_dec;
				if (cnt_dec == '0) begin
					state_d = S_FIN;
				end else begin
					val_d       = rdata_b;
					pos_d       = ROOT;
					mem.raddr_a = pos_addr({ROOT, 1'b0});
					mem.raddr_b = pos_addr({ROOT, 1'b1});
					state_d     = S_DOWN;
				end
			end
			S_DOWN: begin
				mem.we = 1'b1;
				if (pick_l || pick_r) begin
					// Larger child moves up into the hole.
					mem.wdata   = child_v;
					pos_d       = child[COUNT_W-1:0];
					mem.raddr_a = pos_addr({child[COUNT_W-1:0], 1'b0});
					mem.raddr_b = pos_addr({child[COUNT_W-1:0], 1'b1});
				end else begin
					state_d = S_FIN;
				end
			end
			S_PUT: begin
				mem.we  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Working registers of the request in flight.
	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		val_q    <= val_d;
		op_q     <= op_d;
		status_q <= status_d;
		maxv_q   <= maxv_d;
	end

	assign req_ready     = (state_q == S_IDLE);
	assign rsp_valid     = (state_q == S_FIN);
	assign rsp.status    = status_q;
	assign rsp.max_value = maxv_q;
	assign rsp.count     = cnt_q;

`ifndef SYNTHESIS
	// The entry count never passes the capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT)
		else $error("entry count above capacity");

	// While sifting, the hole lies inside the occupied part of the heap.
	a_up_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP) |-> (pos_q > ROOT && pos_q <= cnt_q))
		else $error("sift-up position out of range");

	a_down_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOWN) |-> (pos_q != '0 && pos_q <= cnt_q))
		else $error("sift-down position out of range");

	// An empty report leaves an empty heap and no value.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && status_q == ST_EMPTY) |-> (cnt_q == '0 && maxv_q == '0))
		else $error("empty report with entries held");

	// A dropped push only happens on a full heap.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && status_q == ST_FULL) |-> (cnt_q == CAP_CNT))
		else $error("full report below capacity");
`endif

endmodule

>>> tb/heap_checker.sv
// Response checker for the max-heap priority queue: watches both channels,
// keeps its own heap and compares every response. Depends on mhpq_pkg.
`timescale 1ns / 1ps

module heap_checker
	import mhpq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_data,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_data,
	output int   errors,
	output int   pending
);

	// Predicted heap contents, one-based, and the number of live entries.
	logic [VALUE_W-1:0] heap_mem [1:CAPACITY];
	int                 heap_fill;
	rsp_t               expected_rsp_q [$];

	function automatic void swap_slots(input int a, input int b);
		logic [VALUE_W-1:0] t;
		t           = heap_mem[a];
		heap_mem[a] = heap_mem[b];
		heap_mem[b] = t;
	endfunction

	// Applies one request to the predicted heap and returns its response.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int   pos;
		int   parent;
		int   left;
		int   right;
		int   larger;
		res        = '0;
		res.status = ST_OK;
		if (r.op == OP_PUSH) begin
			if (heap_fill >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// Append, then move the new value up past smaller parents.
				heap_fill++;
				heap_mem[heap_fill] = r.value;
				pos = heap_fill;
				while (pos > 1) begin
					parent = pos / 2;
					if (heap_mem[pos] <= heap_mem[parent])
						break;
					swap_slots(pos, parent);
					pos = parent;
				end
			end
		end else begin
			if (heap_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				// Take the root, move the last entry there and push it down.
				res.max_value = heap_mem[1];
				heap_mem[1]   = heap_mem[heap_fill];
				heap_fill--;
				pos = 1;
				forever begin
					left   = pos * 2;
					right  = left + 1;
					larger = pos;
					if (left <= heap_fill && heap_mem[left] > heap_mem[larger])
						larger = left;
					if (right <= heap_fill && heap_mem[right] > heap_mem[larger])
						larger = right;
					if (larger == pos)
						break;
					swap_slots(pos, larger);
					pos = larger;
				end
			end
		end
		res.count = COUNT_W'(heap_fill);
		return res;
	endfunction

	// Responses are checked before the request of the same edge is predicted,
	// since a response can never belong to a request accepted at that edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		int   err_now;
		if (!arst_n) begin
			heap_fill = 0;
			expected_rsp_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			err_now = 0;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with no request outstanding: status %0d max_value %0d count %0d",
						rsp_data.status, rsp_data.max_value, rsp_data.count);
					err_now++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp_data.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
						err_now++;
					end
					if (rsp_data.max_value !== exp_rsp.max_value) begin
						$error("max_value: expected %0d, got %0d",
							exp_rsp.max_value, rsp_data.max_value);
						err_now++;
					end
					if (rsp_data.count !== exp_rsp.count) begin
						$error("count: expected %0d, got %0d", exp_rsp.count, rsp_data.count);
						err_now++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(apply_request(req_data));
			errors  <= errors + err_now;
			pending <= expected_rsp_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Testbench top for max_heap_priority_queue: clock, reset, request stimulus,
// response stalls, watchdog and verdict; also needs mhpq_pkg and heap_checker.
`timescale 1ns / 1ps

module testbench;
	import mhpq_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	int   errors;
	int   pending;

	// Stimulus-side view of the heap occupancy, used only to shape the phases.
	int level       = 0;
	int burst_left  = 0;
	int ready_left  = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	max_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	heap_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.errors    (errors),
		.pending   (pending)
	);

	// The receiver alternates long ready runs, stalls and random toggling.
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			case ($urandom_range(0, 5))
				0: begin
					rsp_ready  <= 1'b1;
					ready_left <= $urandom_range(50, 200);
				end
				1, 2: begin
					rsp_ready  <= 1'b0;
					ready_left <= $urandom_range(0, 15);
				end
				default: begin
					rsp_ready  <= 1'($urandom_range(0, 1));
					ready_left <= $urandom_range(0, 8);
				end
			endcase
		end
	end

	// The run ends if neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Mostly full-width values, with extremes and a narrow range to force ties.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return VALUE_MAX;
			2, 3:    return VALUE_W'($urandom_range(0, 15));
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// Sends one request and returns at the edge that accepts it. Gaps between
	// bursts are taken before raising valid, so valid never drops mid-burst.
	task automatic send_req(input logic op, input logic [VALUE_W-1:0] value);
		if (burst_left == 0) begin
			if (req_valid) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		req_valid   <= 1'b1;
		req_data.op    <= op;
		req_data.value <= value;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		burst_left--;
		if (op == OP_PUSH && level < CAPACITY)
			level++;
		else if (op == OP_POP && level > 0)
			level--;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pops on an empty heap, extreme values, equal values.
		send_req(OP_POP, VALUE_MAX);
		send_req(OP_POP, '0);
		send_req(OP_PUSH, '0);
		send_req(OP_PUSH, VALUE_MAX);
		send_req(OP_PUSH, VALUE_MAX);
		send_req(OP_PUSH, 31'h2AAAAAAA);
		send_req(OP_PUSH, 31'h55555555);
		send_req(OP_PUSH, 31'd5);
		send_req(OP_PUSH, 31'd5);
		send_req(OP_PUSH, 31'd7);
		while (level > 0)
			send_req(OP_POP, VALUE_W'($urandom()));
		send_req(OP_POP, VALUE_MAX);

		// Directed: after the first pop the moved entry faces two equal children.
		send_req(OP_PUSH, 31'd9);
		send_req(OP_PUSH, 31'd4);
		send_req(OP_PUSH, 31'd4);
		send_req(OP_PUSH, 31'd1);
		send_req(OP_POP, '0);
		send_req(OP_POP, '0);

		// Random mix of pushes and pops around a shallow heap.
		repeat (250) begin
			if ($urandom_range(0, 1) == 0)
				send_req(OP_PUSH, pick_value());
			else
				send_req(OP_POP, VALUE_W'($urandom()));
		end

		// Fill the heap to capacity with random values.
		while (level < CAPACITY)
			send_req(OP_PUSH, pick_value());

		// Work the full boundary: dropped pushes, refills and pops.
		repeat (15) begin
			case ($urandom_range(0, 2))
				0:       send_req(OP_POP, VALUE_W'($urandom()));
				default: send_req(OP_PUSH, pick_value());
			endcase
		end

		// Drain with mostly pops through a deep heap.
		repeat (530) begin
			if ($urandom_range(0, 9) == 0)
				send_req(OP_PUSH, pick_value());
			else
				send_req(OP_POP, VALUE_W'($urandom()));
		end
		req_valid <= 1'b0;

		// Let every outstanding response arrive, then allow a short tail.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
